FILE: rtl/spmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_pkg
// Shared types, constants and arithmetic helpers for the segment pair
// minimum distance core and its length unit.
// ----------------------------------------------------------------------------
package spmd_pkg;

    // coordinate and derived widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int VEC_W   = DIFF_W + 1;
    localparam int DIST_W  = COORD_W + 1;
    localparam int MANT_W  = 15;
    localparam int TFRAC   = 15;
    localparam int Q_W     = TFRAC + 1;
    localparam int DOT_W   = 32;
    localparam int PROD_W  = 64;
    localparam int SH_W    = 5;
    localparam int EX_W    = 6;
    localparam int LEN_S   = 30;

    // configuration port
    localparam int        ADDR_W  = 3;
    localparam int        DATA_W  = 32;
    localparam logic      REG_TOL = 1'b0;
    localparam logic [DATA_W-1:0] TOL_RESET = 32'd1;

    // result branch codes
    localparam logic [2:0] CS_INTERIOR  = 3'd0;
    localparam logic [2:0] CS_PARALLEL  = 3'd1;
    localparam logic [2:0] CS_ONTO_A    = 3'd2;
    localparam logic [2:0] CS_ONTO_B    = 3'd3;
    localparam logic [2:0] CS_ENDPOINTS = 3'd4;

    // pipeline layout
    localparam int DIV_STEPS  = TFRAC + 1;
    localparam int ST_DIFF    = 0;
    localparam int ST_SHIFT   = 1;
    localparam int ST_SCALE   = 2;
    localparam int ST_DOT     = 3;
    localparam int ST_MUL     = 4;
    localparam int ST_SUB     = 5;
    localparam int ST_DEC     = 6;
    localparam int ST_DIV0    = 7;
    localparam int ST_W       = ST_DIV0 + DIV_STEPS;
    localparam int SQ_STEPS   = 32;
    localparam int VLEN_LAT   = 3 + SQ_STEPS + 1;
    localparam int PIPE_DEPTH = ST_W + 1 + VLEN_LAT;
    localparam int LATENCY    = PIPE_DEPTH + 1;

    // where the final distance comes from
    typedef enum logic [1:0] {
        MODE_END,
        MODE_LEN,
        MODE_VEC
    } t_mode;

    typedef logic signed [DIFF_W-1:0] t_dvec [3];
    typedef logic signed [MANT_W-1:0] t_mvec [3];
    typedef logic signed [VEC_W-1:0]  t_wvec [3];

    // magnitude of a difference component
    function automatic logic [DIFF_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] u;
        u = v;
        return v[DIFF_W-1] ? (~u + 1'b1) : u;
    endfunction

    // truncate toward zero after a right shift of the magnitude
    function automatic logic signed [MANT_W-1:0] scale_down(
        input logic signed [DIFF_W-1:0] v,
        input logic [SH_W-1:0] sh
    );
        logic [DIFF_W-1:0] m;
        logic [MANT_W-1:0] q;
        m = mag_d(v) >> sh;
        q = {1'b0, m[MANT_W-2:0]};
        return v[DIFF_W-1] ? $signed(~q + 1'b1) : $signed(q);
    endfunction

    // three term dot product of scaled vectors
    function automatic logic signed [DOT_W-1:0] dot3(input t_mvec p, input t_mvec q);
        return DOT_W'(p[0]) * DOT_W'(q[0]) + DOT_W'(p[1]) * DOT_W'(q[1])
             + DOT_W'(p[2]) * DOT_W'(q[2]);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/spmd_vlen.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spmd_vlen
// Pipelined vector length: normalize, square, sum, one root bit per stage,
// then rescale by the exponent and saturate.
// ----------------------------------------------------------------------------
module spmd_vlen
    import spmd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic signed [VEC_W-1:0]  i_vec [3],
    input  wire logic signed [EX_W-1:0]   i_ex,
    output logic             [DIST_W-1:0] o_len
);

    localparam logic [63:0] DMAX = (64'd1 << DIST_W) - 64'd1;

    logic        [LEN_S-1:0] r_a_m [3];
    logic signed [EX_W-1:0]  r_a_tot;
    logic        [63:0]      r_b_sq [3];
    logic signed [EX_W-1:0]  r_b_tot;
    logic        [63:0]      r_c_sum;
    logic signed [EX_W-1:0]  r_c_tot;
    logic        [63:0]      r_x   [SQ_STEPS];
    logic        [63:0]      r_res [SQ_STEPS];
    logic signed [EX_W-1:0]  r_tot [SQ_STEPS];
    logic        [63:0]      n_x   [SQ_STEPS];
    logic        [63:0]      n_res [SQ_STEPS];
    logic        [DIST_W-1:0] r_len;

    logic [VEC_W-1:0] m [3];
    logic [VEC_W-1:0] m_or;
    logic [2:0]       s;

    // magnitudes and the shift that brings them below 2^30
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m[k] = i_vec[k][VEC_W-1] ? (~i_vec[k] + 1'b1) : i_vec[k];
        end
        m_or = m[0] | m[1] | m[2];
        s = 3'd0;
        for (int b = LEN_S; b < VEC_W; b++) begin
            if (m_or[b]) begin
                s = 3'(b - LEN_S + 1);
            end
        end
    end

    // normalize, square, sum
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_a_m[k]  <= LEN_S'(m[k] >> s);
            r_b_sq[k] <= 64'(r_a_m[k]) * 64'(r_a_m[k]);
        end
        r_a_tot <= i_ex + EX_W'(s);
        r_b_tot <= r_a_tot;
        r_c_sum <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        r_c_tot <= r_b_tot;
    end

    // integer square root, one result bit per stage
    always_comb begin
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        for (int i = 0; i < SQ_STEPS; i++) begin
            x    = (i == 0) ? r_c_sum : r_x[(i == 0) ? 0 : i - 1];
            res  = (i == 0) ? 64'd0   : r_res[(i == 0) ? 0 : i - 1];
            bitv = 64'd1 << (62 - 2 * i);
            if (x >= res + bitv) begin
                n_x[i]   = x - (res + bitv);
                n_res[i] = (res >> 1) + bitv;
            end else begin
                n_x[i]   = x;
                n_res[i] = res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SQ_STEPS; i++) begin
            r_x[i]   <= n_x[i];
            r_res[i] <= n_res[i];
            r_tot[i] <= (i == 0) ? r_c_tot : r_tot[(i == 0) ? 0 : i - 1];
        end
    end

    // rescale by the exponent and saturate
    always_ff @(posedge i_clk) begin
        logic [63:0] rs;
        rs = 64'd0;
        if (!r_tot[SQ_STEPS-1][EX_W-1]) begin
            rs = r_res[SQ_STEPS-1] << r_tot[SQ_STEPS-1];
        end else begin
            rs = r_res[SQ_STEPS-1] >> EX_W'(-r_tot[SQ_STEPS-1]);
        end
        r_len <= (rs > DMAX) ? DMAX[DIST_W-1:0] : rs[DIST_W-1:0];
    end

    assign o_len = r_len;

endmodule
`default_nettype wire

FILE: rtl/segment_pair_min_distance_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// segment_pair_min_distance_core
// Least distance between two 3D line segments given in signed Q16.16.
// ----------------------------------------------------------------------------
// Takes one segment pair on every clock cycle (busy never rises) and returns
// its result on o_valid; results come out in request order and cannot be held
// off. The latency is set by the 16-step fraction divider and by the 36-stage
// vector length units, whose square root resolves one bit per stage. The
// tolerance register may only be written while no request is in flight.
module segment_pair_min_distance_core
    import spmd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // request channel
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [COORD_W-1:0] i_a_start_x,
    input  wire logic signed [COORD_W-1:0] i_a_start_y,
    input  wire logic signed [COORD_W-1:0] i_a_start_z,
    input  wire logic signed [COORD_W-1:0] i_a_end_x,
    input  wire logic signed [COORD_W-1:0] i_a_end_y,
    input  wire logic signed [COORD_W-1:0] i_a_end_z,
    input  wire logic signed [COORD_W-1:0] i_b_start_x,
    input  wire logic signed [COORD_W-1:0] i_b_start_y,
    input  wire logic signed [COORD_W-1:0] i_b_start_z,
    input  wire logic signed [COORD_W-1:0] i_b_end_x,
    input  wire logic signed [COORD_W-1:0] i_b_end_y,
    input  wire logic signed [COORD_W-1:0] i_b_end_z,
    // result channel
    output logic                          o_valid,
    output logic             [DIST_W-1:0] o_distance,
    output logic                          o_parallel,
    output logic             [2:0]        o_closest_case,
    output logic                          o_zero_length,
    // configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic        [ADDR_W-1:0] paddr,
    input  wire logic        [DATA_W-1:0] pwdata,
    output logic             [DATA_W-1:0] prdata,
    output logic                          pready
);

    typedef struct {
        t_dvec                     d1;
        t_dvec                     d2;
        t_dvec                     ev [4];
        logic                      zl;
        logic [SH_W-1:0]           sh;
        t_mvec                     d1n;
        t_mvec                     d2n;
        t_mvec                     rn;
        t_mvec                     e01n;
        t_mvec                     e10p;
        logic signed [DOT_W-1:0]   a, b, c, d, e, f, g;
        logic signed [PROD_W-1:0]  ac, bb, be, cd, ae, bd;
        logic signed [PROD_W-1:0]  denom, n1, n2;
        logic [PROD_W-1:0]         tlo, thi;
        t_mode                     mode;
        logic [2:0]                cs;
        logic                      par;
        logic [1:0]                idx;
        logic [PROD_W-1:0]         rem0, den0, rem1, den1;
        logic [Q_W-1:0]            q0, q1;
        t_mvec                     sv;
        t_mvec                     dv;
        t_wvec                     w;
        logic signed [EX_W-1:0]    ex;
    } t_item;

    logic [DATA_W-1:0]     r_tol;
    logic [PIPE_DEPTH-1:0] r_vld;
    t_item                 r_pipe [PIPE_DEPTH];
    t_item                 n_pipe [PIPE_DEPTH];
    logic                  accept;
    logic                  cfg_wr;

    logic                  r_out_vld;
    logic [DIST_W-1:0]     r_dist;
    logic                  r_par;
    logic [2:0]            r_cs;
    logic                  r_zl;

    t_wvec                 ep_vec [4];
    logic [DIST_W-1:0]     ep_len [4];
    logic [DIST_W-1:0]     w_len;
    logic signed [EX_W-1:0] ep_ex;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (cfg_wr && paddr[ADDR_W-1] == REG_TOL) begin
            r_tol <= pwdata;
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_TOL) ? r_tol : '0;

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_pipe <= n_pipe;
    end

    // stage logic
    always_comb begin
        t_dvec                   pa [2];
        t_dvec                   pb [2];
        logic [DIFF_W-1:0]       maxm;
        logic [95:0]             prod;
        logic [95:0]             lhs;
        logic                    solve_ok;
        logic                    below;
        logic                    in1;
        logic                    in2;
        logic                    sel;
        logic signed [DOT_W-1:0] tnum;
        logic [PROD_W-1:0]       dd;

        for (int k = 1; k < PIPE_DEPTH; k++) begin
            n_pipe[k] = r_pipe[k-1];
        end
        n_pipe[ST_DIFF] = r_pipe[ST_DIFF];

        // endpoint differences
        pa[0][0] = DIFF_W'(i_a_start_x);
        pa[0][1] = DIFF_W'(i_a_start_y);
        pa[0][2] = DIFF_W'(i_a_start_z);
        pa[1][0] = DIFF_W'(i_a_end_x);
        pa[1][1] = DIFF_W'(i_a_end_y);
        pa[1][2] = DIFF_W'(i_a_end_z);
        pb[0][0] = DIFF_W'(i_b_start_x);
        pb[0][1] = DIFF_W'(i_b_start_y);
        pb[0][2] = DIFF_W'(i_b_start_z);
        pb[1][0] = DIFF_W'(i_b_end_x);
        pb[1][1] = DIFF_W'(i_b_end_y);
        pb[1][2] = DIFF_W'(i_b_end_z);
        for (int k = 0; k < 3; k++) begin
            n_pipe[ST_DIFF].d1[k] = pa[1][k] - pa[0][k];
            n_pipe[ST_DIFF].d2[k] = pb[1][k] - pb[0][k];
            for (int i = 0; i < 2; i++) begin
                for (int j = 0; j < 2; j++) begin
                    n_pipe[ST_DIFF].ev[2*i+j][k] = pa[i][k] - pb[j][k];
                end
            end
        end

        // zero length and common scale shift
        maxm = '0;
        for (int k = 0; k < 3; k++) begin
            maxm = maxm | mag_d(r_pipe[ST_DIFF].d1[k]) | mag_d(r_pipe[ST_DIFF].d2[k])
                 | mag_d(r_pipe[ST_DIFF].ev[0][k]) | mag_d(r_pipe[ST_DIFF].ev[1][k])
                 | mag_d(r_pipe[ST_DIFF].ev[2][k]);
        end
        n_pipe[ST_SHIFT].zl =
            (r_pipe[ST_DIFF].d1[0] == 0 && r_pipe[ST_DIFF].d1[1] == 0 &&
             r_pipe[ST_DIFF].d1[2] == 0) ||
            (r_pipe[ST_DIFF].d2[0] == 0 && r_pipe[ST_DIFF].d2[1] == 0 &&
             r_pipe[ST_DIFF].d2[2] == 0);
        n_pipe[ST_SHIFT].sh = '0;
        for (int b = MANT_W - 1; b < DIFF_W; b++) begin
            if (maxm[b]) begin
                n_pipe[ST_SHIFT].sh = SH_W'(b - (MANT_W - 2));
            end
        end

        // scaled vectors
        for (int k = 0; k < 3; k++) begin
            n_pipe[ST_SCALE].d1n[k]  = scale_down(r_pipe[ST_SHIFT].d1[k], r_pipe[ST_SHIFT].sh);
            n_pipe[ST_SCALE].d2n[k]  = scale_down(r_pipe[ST_SHIFT].d2[k], r_pipe[ST_SHIFT].sh);
            n_pipe[ST_SCALE].rn[k]   = scale_down(r_pipe[ST_SHIFT].ev[0][k],
                                                  r_pipe[ST_SHIFT].sh);
            n_pipe[ST_SCALE].e01n[k] = scale_down(r_pipe[ST_SHIFT].ev[1][k],
                                                  r_pipe[ST_SHIFT].sh);
            n_pipe[ST_SCALE].e10p[k] = scale_down(r_pipe[ST_SHIFT].ev[2][k],
                                                  r_pipe[ST_SHIFT].sh);
        end

        // dot products
        n_pipe[ST_DOT].a = dot3(r_pipe[ST_SCALE].d1n, r_pipe[ST_SCALE].d1n);
        n_pipe[ST_DOT].b = dot3(r_pipe[ST_SCALE].d1n, r_pipe[ST_SCALE].d2n);
        n_pipe[ST_DOT].c = dot3(r_pipe[ST_SCALE].d2n, r_pipe[ST_SCALE].d2n);
        n_pipe[ST_DOT].d = dot3(r_pipe[ST_SCALE].d1n, r_pipe[ST_SCALE].rn);
        n_pipe[ST_DOT].e = dot3(r_pipe[ST_SCALE].d2n, r_pipe[ST_SCALE].rn);
        n_pipe[ST_DOT].f = dot3(r_pipe[ST_SCALE].d1n, r_pipe[ST_SCALE].e01n);
        n_pipe[ST_DOT].g = dot3(r_pipe[ST_SCALE].d2n, r_pipe[ST_SCALE].e10p);

        // pairwise products
        n_pipe[ST_MUL].ac = PROD_W'(r_pipe[ST_DOT].a) * PROD_W'(r_pipe[ST_DOT].c);
        n_pipe[ST_MUL].bb = PROD_W'(r_pipe[ST_DOT].b) * PROD_W'(r_pipe[ST_DOT].b);
        n_pipe[ST_MUL].be = PROD_W'(r_pipe[ST_DOT].b) * PROD_W'(r_pipe[ST_DOT].e);
        n_pipe[ST_MUL].cd = PROD_W'(r_pipe[ST_DOT].c) * PROD_W'(r_pipe[ST_DOT].d);
        n_pipe[ST_MUL].ae = PROD_W'(r_pipe[ST_DOT].a) * PROD_W'(r_pipe[ST_DOT].e);
        n_pipe[ST_MUL].bd = PROD_W'(r_pipe[ST_DOT].b) * PROD_W'(r_pipe[ST_DOT].d);

        // determinant, numerators and tolerance partial products
        n_pipe[ST_SUB].denom = r_pipe[ST_MUL].ac - r_pipe[ST_MUL].bb;
        n_pipe[ST_SUB].n1    = r_pipe[ST_MUL].be - r_pipe[ST_MUL].cd;
        n_pipe[ST_SUB].n2    = r_pipe[ST_MUL].ae - r_pipe[ST_MUL].bd;
        n_pipe[ST_SUB].tlo   = PROD_W'(r_tol) * PROD_W'(r_pipe[ST_MUL].ac[31:0]);
        n_pipe[ST_SUB].thi   = PROD_W'(r_tol) * PROD_W'(r_pipe[ST_MUL].ac[63:32]);

        // branch decision and divider operands
        prod = {r_pipe[ST_SUB].thi, 32'd0} + {32'd0, r_pipe[ST_SUB].tlo};
        lhs  = {r_pipe[ST_SUB].denom, 32'd0};
        below = lhs < prod;
        solve_ok = !r_pipe[ST_SUB].zl && r_pipe[ST_SUB].a != 0 && r_pipe[ST_SUB].c != 0;
        in1 = !r_pipe[ST_SUB].n1[PROD_W-1] && r_pipe[ST_SUB].n1 <= r_pipe[ST_SUB].denom;
        in2 = !r_pipe[ST_SUB].n2[PROD_W-1] && r_pipe[ST_SUB].n2 <= r_pipe[ST_SUB].denom;
        sel  = 1'b0;
        tnum = '0;
        dd   = PROD_W'(r_pipe[ST_SUB].a);
        n_pipe[ST_DEC].mode = MODE_END;
        n_pipe[ST_DEC].cs   = CS_ENDPOINTS;
        n_pipe[ST_DEC].par  = 1'b0;
        n_pipe[ST_DEC].idx  = 2'd0;
        n_pipe[ST_DEC].rem0 = '0;
        n_pipe[ST_DEC].den0 = PROD_W'(1);
        n_pipe[ST_DEC].rem1 = '0;
        n_pipe[ST_DEC].den1 = PROD_W'(1);
        n_pipe[ST_DEC].q0   = '0;
        n_pipe[ST_DEC].q1   = '0;
        n_pipe[ST_DEC].sv   = r_pipe[ST_SUB].rn;
        n_pipe[ST_DEC].dv   = r_pipe[ST_SUB].d1n;
        priority if (!solve_ok) begin
            n_pipe[ST_DEC].mode = MODE_END;
        end else if (r_pipe[ST_SUB].denom <= 0 || below) begin
            n_pipe[ST_DEC].par = 1'b1;
            n_pipe[ST_DEC].cs  = CS_PARALLEL;
        end else if (in1 && in2) begin
            n_pipe[ST_DEC].mode = MODE_VEC;
            n_pipe[ST_DEC].cs   = CS_INTERIOR;
            n_pipe[ST_DEC].rem0 = r_pipe[ST_SUB].n1;
            n_pipe[ST_DEC].den0 = r_pipe[ST_SUB].denom;
            n_pipe[ST_DEC].rem1 = r_pipe[ST_SUB].n2;
            n_pipe[ST_DEC].den1 = r_pipe[ST_SUB].denom;
        end else if (in1 || in2) begin
            // endpoint of the other segment projected onto the in-range one
            if (in1) begin
                sel  = !r_pipe[ST_SUB].n2[PROD_W-1];
                tnum = sel ? -r_pipe[ST_SUB].f : -r_pipe[ST_SUB].d;
                dd   = PROD_W'(r_pipe[ST_SUB].a);
                n_pipe[ST_DEC].cs = CS_ONTO_A;
                n_pipe[ST_DEC].sv = sel ? r_pipe[ST_SUB].e01n : r_pipe[ST_SUB].rn;
                n_pipe[ST_DEC].dv = r_pipe[ST_SUB].d1n;
            end else begin
                sel  = !r_pipe[ST_SUB].n1[PROD_W-1];
                tnum = sel ? r_pipe[ST_SUB].g : r_pipe[ST_SUB].e;
                dd   = PROD_W'(r_pipe[ST_SUB].c);
                n_pipe[ST_DEC].cs = CS_ONTO_B;
                for (int k = 0; k < 3; k++) begin
                    n_pipe[ST_DEC].sv[k] = sel ? -r_pipe[ST_SUB].e10p[k]
                                               : -r_pipe[ST_SUB].rn[k];
                end
                n_pipe[ST_DEC].dv = r_pipe[ST_SUB].d2n;
            end
            if (tnum[DOT_W-1]) begin
                n_pipe[ST_DEC].mode = MODE_LEN;
                n_pipe[ST_DEC].idx  = in1 ? {1'b0, sel} : {sel, 1'b0};
            end else if (PROD_W'(tnum) > dd) begin
                n_pipe[ST_DEC].mode = MODE_LEN;
                n_pipe[ST_DEC].idx  = in1 ? {1'b1, sel} : {sel, 1'b1};
            end else begin
                n_pipe[ST_DEC].mode = MODE_VEC;
                n_pipe[ST_DEC].rem0 = PROD_W'(tnum);
                n_pipe[ST_DEC].den0 = dd;
            end
        end else begin
            n_pipe[ST_DEC].cs = CS_ENDPOINTS;
        end

        // restoring fraction dividers, one quotient bit per stage
        for (int s = 0; s < DIV_STEPS; s++) begin
            if (s > 0) begin
                n_pipe[ST_DIV0+s].rem0 = r_pipe[ST_DIV0+s-1].rem0 << 1;
                n_pipe[ST_DIV0+s].q0   = r_pipe[ST_DIV0+s-1].q0 << 1;
                n_pipe[ST_DIV0+s].rem1 = r_pipe[ST_DIV0+s-1].rem1 << 1;
                n_pipe[ST_DIV0+s].q1   = r_pipe[ST_DIV0+s-1].q1 << 1;
            end
            if (n_pipe[ST_DIV0+s].rem0 >= n_pipe[ST_DIV0+s].den0) begin
                n_pipe[ST_DIV0+s].rem0 = n_pipe[ST_DIV0+s].rem0 - n_pipe[ST_DIV0+s].den0;
                n_pipe[ST_DIV0+s].q0   = n_pipe[ST_DIV0+s].q0 | Q_W'(1);
            end
            if (n_pipe[ST_DIV0+s].rem1 >= n_pipe[ST_DIV0+s].den1) begin
                n_pipe[ST_DIV0+s].rem1 = n_pipe[ST_DIV0+s].rem1 - n_pipe[ST_DIV0+s].den1;
                n_pipe[ST_DIV0+s].q1   = n_pipe[ST_DIV0+s].q1 | Q_W'(1);
            end
        end

        // point difference vector and its exponent
        for (int k = 0; k < 3; k++) begin
            n_pipe[ST_W].w[k] =
                (VEC_W'(r_pipe[ST_W-1].sv[k]) <<< TFRAC)
              + VEC_W'($signed({1'b0, r_pipe[ST_W-1].q0})) * VEC_W'(r_pipe[ST_W-1].dv[k])
              - VEC_W'($signed({1'b0, r_pipe[ST_W-1].q1})) * VEC_W'(r_pipe[ST_W-1].d2n[k]);
        end
        n_pipe[ST_W].ex = $signed(EX_W'(r_pipe[ST_W-1].sh)) - EX_W'(TFRAC);
    end

    // length units: four endpoint separations and the solved vector
    assign ep_ex = '0;
    for (genvar q = 0; q < 4; q++) begin : g_ep
        for (genvar k = 0; k < 3; k++) begin : g_comp
            assign ep_vec[q][k] = VEC_W'(r_pipe[ST_W].ev[q][k]);
        end
        spmd_vlen u_ep_len (
            .i_clk (i_clk),
            .i_vec (ep_vec[q]),
            .i_ex  (ep_ex),
            .o_len (ep_len[q])
        );
    end

    spmd_vlen u_w_len (
        .i_clk (i_clk),
        .i_vec (r_pipe[ST_W].w),
        .i_ex  (r_pipe[ST_W].ex),
        .o_len (w_len)
    );

    // final selection
    always_ff @(posedge i_clk) begin
        logic [DIST_W-1:0] m01;
        logic [DIST_W-1:0] m23;
        logic [DIST_W-1:0] endmin;
        m01 = (ep_len[1] < ep_len[0]) ? ep_len[1] : ep_len[0];
        m23 = (ep_len[3] < ep_len[2]) ? ep_len[3] : ep_len[2];
        endmin = (m23 < m01) ? m23 : m01;
        unique case (r_pipe[PIPE_DEPTH-1].mode)
            MODE_END: r_dist <= endmin;
            MODE_LEN: r_dist <= ep_len[r_pipe[PIPE_DEPTH-1].idx];
            MODE_VEC: r_dist <= w_len;
            default:  r_dist <= endmin;
        endcase
        r_par <= r_pipe[PIPE_DEPTH-1].par;
        r_cs  <= r_pipe[PIPE_DEPTH-1].cs;
        r_zl  <= r_pipe[PIPE_DEPTH-1].zl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[PIPE_DEPTH-1];
        end
    end

    assign o_valid        = r_out_vld;
    assign o_distance     = r_dist;
    assign o_parallel     = r_par;
    assign o_closest_case = r_cs;
    assign o_zero_length  = r_zl;

`ifndef NO_ASSERTIONS
    // every request yields exactly one result after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("result missing after request");

    // parallel flag and parallel branch agree
    a_par_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_parallel == (o_closest_case == CS_PARALLEL)))
        else $error("parallel flag and branch code disagree");

    // a degenerate segment always falls back to endpoint separation
    a_zl_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zero_length) |-> (o_closest_case == CS_ENDPOINTS))
        else $error("zero length pair took a solved branch");
`endif

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the segment pair minimum distance core against a cycle-free model
// of its fixed-point arithmetic. Segment pairs stream in bursts with random
// gaps. Each result is compared field by field with the oldest prediction.
// The tolerance register is swept between phases while the core is idle.
// ----------------------------------------------------------------------------
module testbench;
    import spmd_pkg::*;

    typedef logic signed [COORD_W-1:0] seg_pair_t [12];
    typedef longint vec3_t [3];
    typedef struct packed {
        logic [DIST_W-1:0] dst;
        logic              par;
        logic [2:0]        cs;
        logic              zl;
    } seg_result_t;

    localparam logic [ADDR_W-1:0] TOL_ADDR   = 3'd0;
    localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    seg_pair_t cur_pair = '{default: '0};
    logic o_valid;
    logic [DIST_W-1:0] o_distance;
    logic o_parallel;
    logic [2:0] o_closest_case;
    logic o_zero_length;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    seg_pair_t pending_pairs [$];
    seg_result_t expected_results [$];
    logic [31:0] tol_q = TOL_RESET;
    int errors = 0;
    int n_accepted = 0, n_popped = 0, n_checked = 0;
    int cycles = 0;
    int burst_left = 0, gap_left = 0;
    int case_hits [5] = '{default: 0};

    segment_pair_min_distance_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_a_start_x(cur_pair[0]), .i_a_start_y(cur_pair[1]), .i_a_start_z(cur_pair[2]),
        .i_a_end_x(cur_pair[3]), .i_a_end_y(cur_pair[4]), .i_a_end_z(cur_pair[5]),
        .i_b_start_x(cur_pair[6]), .i_b_start_y(cur_pair[7]), .i_b_start_z(cur_pair[8]),
        .i_b_end_x(cur_pair[9]), .i_b_end_y(cur_pair[10]), .i_b_end_z(cur_pair[11]),
        .o_valid(o_valid), .o_distance(o_distance), .o_parallel(o_parallel),
        .o_closest_case(o_closest_case), .o_zero_length(o_zero_length),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- distance arithmetic ----------------

    function automatic longint unsigned abs_val(longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    function automatic longint shrink(longint v, int sh);
        longint q;
        q = longint'(abs_val(v) >> sh);
        return v < 0 ? -q : q;
    endfunction

    function automatic longint dot(vec3_t p, vec3_t q);
        return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // floor(num * 2^15 / den)
    function automatic longint unsigned ratio_q15(longint unsigned num, longint unsigned den);
        longint unsigned q, rem;
        q = 0;
        rem = num;
        if (rem >= den) begin
            q = 1;
            rem = rem - den;
        end
        for (int k = 0; k < TFRAC; k++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den) begin
                rem = rem - den;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    function automatic longint unsigned vec_length(vec3_t v, int ex);
        longint unsigned m [3];
        longint unsigned sum, r, dmax, t;
        int s, tot;
        dmax = (64'd1 << DIST_W) - 1;
        s = 0;
        sum = 0;
        for (int k = 0; k < 3; k++) m[k] = abs_val(v[k]);
        while (((m[0] | m[1] | m[2]) >> s) >= (64'd1 << LEN_S)) s++;
        for (int k = 0; k < 3; k++) begin
            t = m[k] >> s;
            sum = sum + t * t;
        end
        r = int_sqrt(sum);
        tot = s + ex;
        if (tot >= 0) begin
            if (tot >= 63) return r != 0 ? dmax : 0;
            if (r > (dmax >> tot)) return dmax;
            return r << tot;
        end
        if (-tot >= 63) return 0;
        r = r >> (-tot);
        return r > dmax ? dmax : r;
    endfunction

    // (denom << 32) < tol * ac in 128 bits
    function automatic bit under_tolerance(longint unsigned denom, longint unsigned ac,
                                           logic [31:0] tol);
        logic [127:0] lhs, rhs;
        lhs = {64'd0, denom} << 32;
        rhs = {96'd0, tol} * {64'd0, ac};
        return lhs < rhs;
    endfunction

    // endpoint projected onto a direction, clamped to the segment
    function automatic longint unsigned clamp_project(vec3_t sme, vec3_t dir, longint dd,
                                                      int sh, vec3_t near0, vec3_t near1);
        longint tnum, tq;
        vec3_t w;
        tnum = -dot(dir, sme);
        if (tnum < 0) return vec_length(near0, 0);
        if (tnum > dd) return vec_length(near1, 0);
        tq = longint'(ratio_q15(64'(tnum), 64'(dd)));
        for (int k = 0; k < 3; k++) w[k] = sme[k] * (64'sd1 <<< TFRAC) + tq * dir[k];
        return vec_length(w, sh - TFRAC);
    endfunction

    function automatic seg_result_t min_distance(seg_pair_t p, logic [31:0] tol);
        vec3_t pa [2];
        vec3_t pb [2];
        vec3_t ev [2][2];
        vec3_t d1, d2, d1n, d2n, rn, e01n, e10n, w, sme;
        longint unsigned endmin, maxm, t, dst;
        longint a, b, c, d, e, denom, n1, n2, t1q, t2q;
        int sh, cs, i, j;
        bit par, zl, in1, in2;
        seg_result_t res;
        for (int k = 0; k < 3; k++) begin
            pa[0][k] = longint'(p[k]);
            pa[1][k] = longint'(p[3 + k]);
            pb[0][k] = longint'(p[6 + k]);
            pb[1][k] = longint'(p[9 + k]);
            d1[k] = pa[1][k] - pa[0][k];
            d2[k] = pb[1][k] - pb[0][k];
        end
        endmin = 0;
        for (int ii = 0; ii < 2; ii++)
            for (int jj = 0; jj < 2; jj++) begin
                for (int k = 0; k < 3; k++) ev[ii][jj][k] = pa[ii][k] - pb[jj][k];
                t = vec_length(ev[ii][jj], 0);
                if ((ii == 0 && jj == 0) || t < endmin) endmin = t;
            end
        zl = (d1[0] == 0 && d1[1] == 0 && d1[2] == 0) || (d2[0] == 0 && d2[1] == 0 && d2[2] == 0);
        // common shift bringing every component below 2^14
        maxm = 0;
        for (int k = 0; k < 3; k++)
            maxm = maxm | abs_val(d1[k]) | abs_val(d2[k]) | abs_val(ev[0][0][k])
                 | abs_val(ev[0][1][k]) | abs_val(ev[1][0][k]);
        sh = 0;
        while ((maxm >> sh) >= (64'd1 << 14)) sh++;
        for (int k = 0; k < 3; k++) begin
            d1n[k] = shrink(d1[k], sh);
            d2n[k] = shrink(d2[k], sh);
            rn[k] = shrink(ev[0][0][k], sh);
            e01n[k] = shrink(ev[0][1][k], sh);
            e10n[k] = -shrink(ev[1][0][k], sh);
        end
        dst = endmin;
        cs = CS_ENDPOINTS;
        par = 0;
        a = dot(d1n, d1n);
        c = dot(d2n, d2n);
        b = dot(d1n, d2n);
        d = dot(d1n, rn);
        e = dot(d2n, rn);
        if (!zl && a != 0 && c != 0) begin
            denom = a * c - b * b;
            if (denom <= 0 || under_tolerance(64'(denom), 64'(a * c), tol)) begin
                par = 1;
                cs = CS_PARALLEL;
            end else begin
                n1 = b * e - c * d;
                n2 = a * e - b * d;
                in1 = n1 >= 0 && n1 <= denom;
                in2 = n2 >= 0 && n2 <= denom;
                if (in1 && in2) begin
                    t1q = longint'(ratio_q15(64'(n1), 64'(denom)));
                    t2q = longint'(ratio_q15(64'(n2), 64'(denom)));
                    for (int k = 0; k < 3; k++)
                        w[k] = rn[k] * (64'sd1 <<< TFRAC) + t1q * d1n[k] - t2q * d2n[k];
                    dst = vec_length(w, sh - TFRAC);
                    cs = CS_INTERIOR;
                end else if (in1) begin
                    j = n2 < 0 ? 0 : 1;
                    for (int k = 0; k < 3; k++) sme[k] = j ? e01n[k] : rn[k];
                    dst = clamp_project(sme, d1n, a, sh, ev[0][j], ev[1][j]);
                    cs = CS_ONTO_A;
                end else if (in2) begin
                    i = n1 < 0 ? 0 : 1;
                    for (int k = 0; k < 3; k++) sme[k] = i ? e10n[k] : -rn[k];
                    dst = clamp_project(sme, d2n, c, sh, ev[i][0], ev[i][1]);
                    cs = CS_ONTO_B;
                end
            end
        end
        res.dst = dst[DIST_W-1:0];
        res.par = par;
        res.cs = 3'(cs);
        res.zl = zl;
        return res;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic signed [31:0] rand_coord();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 3))
            0: return v;
            1: return $signed(v) >>> $urandom_range(0, 31);
            2: return $signed(v) >>> $urandom_range(12, 24);
            default: return $signed(v) >>> $urandom_range(20, 31);
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        int kind, f;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 12; k++) p[k] = rand_coord();
        case (kind)
            // near-parallel: B is A shifted, with a small jitter
            0, 1: begin
                f = $urandom_range(0, 3);
                for (int k = 0; k < 3; k++) begin
                    p[6 + k] = p[k] + ($signed($urandom) >>> 12);
                    p[9 + k] = p[6 + k] + ((p[3 + k] - p[k]) >>> f)
                             + ($signed($urandom) >>> $urandom_range(18, 31));
                end
            end
            // zero-length A or B
            2: begin
                f = $urandom_range(0, 1) ? 0 : 6;
                for (int k = 0; k < 3; k++) p[f + 3 + k] = p[f + k];
            end
            // shared endpoint
            3: for (int k = 0; k < 3; k++) p[6 + k] = p[3 + k];
            // moderate sized pairs around one center
            default: begin
                for (int k = 0; k < 12; k++) p[k] = $signed($urandom) >>> $urandom_range(8, 14);
            end
        endcase
        return p;
    endfunction

    function automatic seg_pair_t axis_pair(int ax, int ay, int az, int bx, int by, int bz,
                                            int cx, int cy, int cz, int dx, int dy, int dz);
        seg_pair_t p;
        p = '{ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz};
        for (int k = 0; k < 12; k++) p[k] = p[k] <<< 16;
        return p;
    endfunction

    task automatic queue_directed();
        seg_pair_t p;
        localparam logic signed [31:0] MX = 32'sh7fffffff;
        localparam logic signed [31:0] MN = 32'sh80000000;
        pending_pairs.push_back('{default: '0});
        pending_pairs.push_back('{MN, MN, MN, MX, MX, MX, MX, MX, MX, MN, MN, MN});
        pending_pairs.push_back('{MN, MN, MN, MN, MN, MN, MX, MX, MX, MX, MX, MX});
        pending_pairs.push_back('{MX, MN, MX, MN, MX, MN, MN, MX, MN, MX, MN, MX});
        pending_pairs.push_back('{default: 32'sh7fffffff});
        pending_pairs.push_back('{default: 32'sh80000000});
        // interior crossing
        pending_pairs.push_back(axis_pair(-4, 0, 0, 4, 0, 0, 0, -4, 3, 0, 4, 3));
        // crossing with no offset
        pending_pairs.push_back(axis_pair(-1, 0, 0, 1, 0, 0, 0, -1, 0, 0, 1, 0));
        // endpoint of B projected onto A
        pending_pairs.push_back(axis_pair(-4, 0, 0, 4, 0, 0, 0, 2, 1, 0, 9, 1));
        // endpoint of A projected onto B
        pending_pairs.push_back(axis_pair(0, 2, 1, 0, 9, 1, -4, 0, 0, 4, 0, 0));
        // both parameters out of range: past the end of A, before the start of B
        pending_pairs.push_back(axis_pair(0, 0, 0, 1, 0, 0, 3, 2, 0, 3, 9, 5));
        // neither parameter in range
        pending_pairs.push_back(axis_pair(0, 0, 0, 1, 0, 0, 5, 5, 1, 5, 9, 2));
        // exactly parallel and antiparallel
        pending_pairs.push_back(axis_pair(0, 0, 0, 5, 5, 5, 1, 0, 0, 6, 5, 5));
        pending_pairs.push_back(axis_pair(0, 0, 0, 5, 5, 5, 7, 7, 8, 2, 2, 3));
        // zero-length A, zero-length B, both
        pending_pairs.push_back(axis_pair(3, 3, 3, 3, 3, 3, 0, 0, 0, 9, 1, 1));
        pending_pairs.push_back(axis_pair(0, 0, 0, 9, 1, 1, 3, 3, 3, 3, 3, 3));
        pending_pairs.push_back(axis_pair(1, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2, 2));
        // short segment that scales to zero next to a huge one
        p = '{0, 0, 0, 1, 0, 0, MN, 0, 0, MX, 5, 5};
        pending_pairs.push_back(p);
        p = '{MN, 0, 0, MX, 3, 0, 5, 5, 5, 5, 6, 5};
        pending_pairs.push_back(p);
        // long, nearly parallel
        p = '{0, 0, 0, 32'sh40000000, 32'sh00000100, 0, 0, 32'sh10000, 0,
              32'sh40000000, 32'sh10000, 1};
        pending_pairs.push_back(p);
        // one raw unit apart
        p = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1, 0};
        pending_pairs.push_back(p);
    endtask

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) pending_pairs.push_back(random_pair());
    endtask

    // ---------------- configuration port ----------------

    task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr == TOL_ADDR) tol_q = data;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic reg_check(logic [ADDR_W-1:0] addr, logic [31:0] want);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t tolerance readback mismatch: expected %h actual %h", $time, want, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() != 0 || expected_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [31:0] tol, int n);
        reg_write(TOL_ADDR, tol);
        reg_write(SPARE_ADDR, $urandom);
        reg_check(TOL_ADDR, tol);
        queue_random(n);
        drain();
    endtask

    // ---------------- sequence ----------------
    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        reg_check(TOL_ADDR, TOL_RESET);
        queue_directed();
        drain();
        run_phase(32'd1, 150);
        run_phase(32'd0, 100);
        run_phase(32'hffffffff, 100);
        run_phase($urandom >> $urandom_range(0, 24), 130);
        run_phase(32'h00400000, 120);
        $display("%0d requests checked across six tolerance phases", n_checked);
        $display("branches: interior %0d parallel %0d onto-A %0d onto-B %0d endpoints %0d",
                 case_hits[0], case_hits[1], case_hits[2], case_hits[3], case_hits[4]);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    // ---------------- driver ----------------
    always @(negedge i_clk) begin
        if (n_accepted != n_popped) begin
            void'(pending_pairs.pop_front());
            n_popped++;
        end
        if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
        end else if (pending_pairs.size() != 0 && i_rst_n) begin
            start <= 1'b1;
            cur_pair <= pending_pairs[0];
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            burst_left--;
            if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
        end else begin
            start <= 1'b0;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        seg_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, expected_results.size());
            $display("Regression FAIL");
            $finish;
        end
        // result check against the oldest prediction
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual dist %h", $time, o_distance);
                errors++;
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (want.cs < 5) case_hits[want.cs]++;
                if (o_distance !== want.dst) begin
                    $display("%0t distance: expected %h actual %h", $time, want.dst, o_distance);
                    errors++;
                end
                if (o_parallel !== want.par) begin
                    $display("%0t parallel: expected %b actual %b", $time, want.par, o_parallel);
                    errors++;
                end
                if (o_closest_case !== want.cs) begin
                    $display("%0t closest_case: expected %0d actual %0d", $time, want.cs,
                             o_closest_case);
                    errors++;
                end
                if (o_zero_length !== want.zl) begin
                    $display("%0t zero_length: expected %b actual %b", $time, want.zl,
                             o_zero_length);
                    errors++;
                end
            end
        end
        // accepted request
        if (i_rst_n && start && !busy) begin
            expected_results.push_back(min_distance(cur_pair, tol_q));
            n_accepted++;
        end
    end

endmodule
